### hdl/cftp_pkg.sv
package cftp_pkg;

  typedef enum logic [6:0] {
    PH_START     = 7'b0000001,
    PH_SIGN      = 7'b0000010,
    PH_ZERO      = 7'b0000100,
    PH_NUM       = 7'b0001000,
    PH_DEN_FIRST = 7'b0010000,
    PH_DEN       = 7'b0100000,
    PH_ERROR     = 7'b1000000
  } phase_e;

  typedef enum logic [3:0] {
    ST_PARSE = 4'b0001,
    ST_GCD   = 4'b0010,
    ST_MOD   = 4'b0100,
    ST_OUT   = 4'b1000
  } ctrl_e;

  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;

  // controller to datapath
  typedef struct packed {
    logic parse;     // consume a non-terminator byte
    logic gcd_load;  // load gcd operands
    logic mod_start; // start one remainder
    logic mod_step;  // one restoring step
    logic mod_done;  // swap after remainder
    logic result;    // capture result
    logic clear;     // back to start of text
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_gcd;
    logic right_zero;
    logic mod_last;
  } sts_t;

endpackage

### hdl/cftp_ctrl.sv
module cftp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     ch_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cftp_pkg::sts_t sts_i,
  output cftp_pkg::cmd_t cmd_o
);
  import cftp_pkg::*;

  ctrl_e state_q, state_d;
  logic  out_valid_q, out_valid_d;
  logic  take;

  assign in_ready_o  = (state_q == ST_PARSE) && !out_valid_q;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_PARSE: begin
        if (take) begin
          if (ch_i != 8'd0) begin
            cmd_o.parse = 1'b1;
          end else if (sts_i.need_gcd) begin
            cmd_o.gcd_load = 1'b1;
            state_d = ST_GCD;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_GCD: begin
        if (sts_i.right_zero) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.mod_start = 1'b1;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          cmd_o.mod_done = 1'b1;
          state_d = ST_GCD;
        end
      end
      ST_OUT: begin
        cmd_o.result = 1'b1;
        cmd_o.clear  = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = ST_PARSE;
      end
      default: state_d = ST_PARSE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

### hdl/cftp_dp.sv
module cftp_dp #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            ch_i,
  input  cftp_pkg::cmd_t        cmd_i,
  output cftp_pkg::sts_t        sts_o,
  output logic                  valid_res_o,
  output logic signed [63:0]    numerator_o,
  output logic [62:0]           denominator_o
);
  import cftp_pkg::*;

  localparam int W  = VALUE_BITS;
  localparam int CW = $clog2(W + 1);
  localparam logic [W:0] HalfRange = {2'b01, {(W - 1){1'b0}}};

  phase_e       phase_q, phase_d;
  logic         neg_q, neg_d;
  logic [W-1:0] num_q, num_d;
  logic [W-1:0] den_q, den_d;
  logic [W-1:0] left_q, left_d, right_q, right_d;
  logic [W-1:0] quo_q, quo_d;   // dividend shifting out
  logic [W-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic         res_v_q;
  logic [W-1:0] res_n_q, res_d_q;

  logic         is_dig, is_nz;
  logic [3:0]   dig;
  logic [W:0]   acc_sel, prod, limit;
  logic         ovf;
  logic [W:0]   rem_sh;
  logic         ok;

  assign is_dig = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign is_nz  = (ch_i >= ChOne) && (ch_i <= ChNine);
  assign dig    = 4'(ch_i - ChZero);

  // shift-add and compare against the limit at W+5 bits
  logic [W+4:0] wide;
  always_comb begin
    acc_sel = (phase_q == PH_DEN) ? {1'b0, den_q} : {1'b0, num_q};
    limit   = (phase_q == PH_NUM && neg_q) ? HalfRange : HalfRange - 1'b1;
    wide    = {acc_sel, 3'b000} + {2'b00, acc_sel, 1'b0} + (W + 5)'(dig);
    ovf     = wide > (W + 5)'(limit);
    prod    = wide[W:0];
  end

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    num_d   = num_q;
    den_d   = den_q;
    if (cmd_i.clear) begin
      phase_d = PH_START;
      neg_d   = 1'b0;
      num_d   = '0;
      den_d   = '0;
    end else if (cmd_i.parse) begin
      unique case (phase_q)
        PH_START: begin
          if (ch_i == ChMinus) begin
            neg_d = 1'b1;
            phase_d = PH_SIGN;
          end else if (ch_i == ChZero) begin
            phase_d = PH_ZERO;
          end else if (is_dig) begin
            num_d = W'(dig);
            phase_d = PH_NUM;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_SIGN: begin
          if (is_nz) begin
            num_d = W'(dig);
            phase_d = PH_NUM;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_NUM: begin
          if (is_dig) begin
            if (ovf) phase_d = PH_ERROR;
            else num_d = prod[W-1:0];
          end else if (ch_i == ChSlash) begin
            phase_d = PH_DEN_FIRST;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_DEN_FIRST: begin
          if (is_nz) begin
            den_d = W'(dig);
            phase_d = PH_DEN;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_DEN: begin
          if (is_dig && !ovf) den_d = prod[W-1:0];
          else phase_d = PH_ERROR;
        end
        PH_ZERO:  phase_d = PH_ERROR;
        PH_ERROR: phase_d = PH_ERROR;
        default:  phase_d = PH_ERROR;
      endcase
    end
  end

  // restoring remainder, one bit per cycle
  assign rem_sh = {rem_q, quo_q[W-1]};
  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    if (cmd_i.gcd_load) begin
      left_d  = num_q;
      right_d = den_q;
    end
    if (cmd_i.mod_start) begin
      quo_d = left_q;
      rem_d = '0;
      cnt_d = CW'(W - 1);
    end
    if (cmd_i.mod_step) begin
      quo_d = {quo_q[W-2:0], 1'b0};
      rem_d = (rem_sh >= {1'b0, right_q}) ? W'(rem_sh - {1'b0, right_q}) : rem_sh[W-1:0];
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.mod_done) begin
      left_d  = right_q;
      right_d = rem_d;
    end
  end

  always_comb begin
    unique case (phase_q) inside
      PH_ZERO, PH_NUM: ok = 1'b1;
      PH_DEN:          ok = (den_q >= W'(2)) && (left_q == W'(1));
      default:         ok = 1'b0;
    endcase
  end

  assign sts_o = '{
    need_gcd:   (phase_q == PH_DEN) && (den_q >= W'(2)),
    right_zero: (right_q == '0),
    mod_last:   (cnt_q == '0)
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      num_q   <= '0;
      den_q   <= '0;
      left_q  <= '0;
      right_q <= '0;
      cnt_q   <= '0;
      res_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      num_q   <= num_d;
      den_q   <= den_d;
      left_q  <= left_d;
      right_q <= right_d;
      cnt_q   <= cnt_d;
      if (cmd_i.result) res_v_q <= ok;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.result) begin
      res_n_q <= !ok ? '0 : (neg_q ? W'(-num_q) : num_q);
      res_d_q <= !ok ? '0 : ((phase_q == PH_DEN) ? den_q : W'(1));
    end
  end

  assign valid_res_o   = res_v_q;
  assign numerator_o   = 64'(signed'(res_n_q));
  assign denominator_o = 63'(res_d_q);
endmodule

### hdl/canonical_fraction_text_parser_core.sv
// canonical fraction text parser
// input channel: one text byte per request on ch_i (in_valid_i / in_ready_o);
// a zero byte ends the text and always produces exactly one result.
// output channel: valid_res_o, numerator_o, denominator_o (out_valid_o /
// out_ready_i); rejected texts give zeros in the value fields.
// a non-zero byte is parsed as it is taken (one shift-add per digit).
// a terminator without a gcd passes through ST_OUT, which registers its result;
// with a denominator of 2 or more the euclid loop first runs on a bit-serial
// remainder unit, one restoring step per remainder bit.
// the result then sits in an output register; no new byte is taken while it
// waits, so a stalled receiver holds off the sender. the next byte can be
// taken in the cycle after the result is accepted.
// reset returns to start of text with no result pending.
module canonical_fraction_text_parser_core #(
  parameter int VALUE_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               valid_res_o,
  output logic signed [63:0] numerator_o,
  output logic [62:0]        denominator_o
);
  import cftp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cftp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .ch_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  cftp_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni, .ch_i, .cmd_i(cmd), .sts_o(sts),
    .valid_res_o, .numerator_o, .denominator_o
  );

  a_no_take_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("byte taken with result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(numerator_o) && $stable(valid_res_o))
    else $error("result changed while stalled");
  a_zero_when_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> numerator_o == 64'd0 && denominator_o == 63'd0)
    else $error("rejected result not zero");
endmodule
